/* hw/rtl/mfb_pkg.sv */
// ============================================================================
// mfb_pkg: shared types and constants for the framebuffer refresh block
// Field widths, serial protocol bytes, opcode codes, controller states and
// the command and status bundles between controller and datapath.
// ============================================================================
package mfb_pkg;

  // Default geometry of the store.
  localparam int ROWS_DEF          = 64;
  localparam int BYTES_PER_ROW_DEF = 16;

  // Row stride of the store in bytes and the column index width it implies.
  localparam int STRIDE = 16;
  localparam int COL_W  = $clog2(STRIDE);

  // Payload field widths.
  localparam int OP_W   = 2;
  localparam int X_W    = 7;
  localparam int Y_W    = 6;
  localparam int VAL_W  = 8;
  localparam int BYTE_W = 8;
  localparam int WORD_W = 24;

  // Row cursor width and the half-screen split used by row addressing.
  localparam int ROW_W     = 6;
  localparam int HALF_ROWS = 32;
  localparam int HALF_W    = $clog2(HALF_ROWS);

  // Serial protocol bytes.
  localparam logic [BYTE_W-1:0] SYNC_CMD  = 8'hF8;
  localparam logic [BYTE_W-1:0] SYNC_DATA = 8'hFA;
  localparam logic [BYTE_W-1:0] NIB_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] ROW_CMD   = 8'h80;
  localparam logic [BYTE_W-1:0] BANK_LO   = 8'h80;
  localparam logic [BYTE_W-1:0] BANK_HI   = 8'h88;

  // Leftmost pixel of a byte sits in the top bit.
  localparam logic [BYTE_W-1:0] PIX_MSB = 8'h80;

  typedef enum logic [OP_W-1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SEND  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_WR,
    ST_SEND_CMD0,
    ST_SEND_CMD1,
    ST_SEND_RD,
    ST_SEND_DATA
  } state_e;

  typedef enum logic [1:0] {
    SEL_CMD0,
    SEL_CMD1,
    SEL_DATA
  } out_sel_e;

  // Controller to datapath.
  typedef struct packed {
    logic     cap_en;
    logic     rd_en;
    logic     rd_send;
    logic     wr_en;
    logic     wr_zero;
    logic     sweep_step;
    logic     byte_step;
    logic     out_load;
    out_sel_e out_sel;
    logic     cursor_adv;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    opcode_e in_op;
    logic    draw_ok;
    logic    sweep_last;
    logic    byte_last;
    logic    out_free;
  } ctrl_sts_t;

endpackage

/* hw/rtl/mfb_if.sv */
// ============================================================================
// mfb_if: valid/ready channels of the framebuffer refresh block
// The request channel carries draw, clear, send and no-op beats; the transfer
// channel carries one serial display transfer per beat.
// ============================================================================
interface mfb_in_if;
  logic                        valid;
  logic                        ready;
  logic [mfb_pkg::OP_W-1:0]    opcode;
  logic [mfb_pkg::X_W-1:0]     x_pos;
  logic [mfb_pkg::Y_W-1:0]     y_pos;
  logic [mfb_pkg::VAL_W-1:0]   pixel_value;

  modport source (output valid, opcode, x_pos, y_pos, pixel_value, input ready);
  modport sink   (input valid, opcode, x_pos, y_pos, pixel_value, output ready);
endinterface

interface mfb_out_if;
  logic                        valid;
  logic                        ready;
  logic                        is_data;
  logic [mfb_pkg::BYTE_W-1:0]  payload_byte;
  logic [mfb_pkg::WORD_W-1:0]  serial_word;
  logic                        row_last;
  logic                        frame_last;

  modport source (output valid, is_data, payload_byte, serial_word, row_last, frame_last,
                  input ready);
  modport sink   (input valid, is_data, payload_byte, serial_word, row_last, frame_last,
                  output ready);
endinterface

/* hw/rtl/mfb_ctrl.sv */
// ============================================================================
// mfb_ctrl: sequencing controller of the framebuffer refresh block
// Decodes request beats and steps the datapath through the clearing sweep,
// the pixel read-modify-write and the row transfer sequence.
// ============================================================================
module mfb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  mfb_pkg::ctrl_sts_t    sts_i,
  output mfb_pkg::ctrl_cmd_t    cmd_o
);

  mfb_pkg::state_e state_q, state_d;

  // State register; reset starts with a sweep that zeroes the store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfb_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mfb_pkg::ST_CLEAR: begin
        if (sts_i.sweep_last) state_d = mfb_pkg::ST_IDLE;
      end
      mfb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (sts_i.in_op)
            mfb_pkg::OP_DRAW:  state_d = sts_i.draw_ok ? mfb_pkg::ST_PIX_WR : mfb_pkg::ST_IDLE;
            mfb_pkg::OP_CLEAR: state_d = mfb_pkg::ST_CLEAR;
            mfb_pkg::OP_SEND:  state_d = mfb_pkg::ST_SEND_CMD0;
            default:           state_d = mfb_pkg::ST_IDLE;
          endcase
        end
      end
      mfb_pkg::ST_PIX_WR: begin
        state_d = mfb_pkg::ST_IDLE;
      end
      mfb_pkg::ST_SEND_CMD0: begin
        if (sts_i.out_free) state_d = mfb_pkg::ST_SEND_CMD1;
      end
      mfb_pkg::ST_SEND_CMD1: begin
        if (sts_i.out_free) state_d = mfb_pkg::ST_SEND_RD;
      end
      mfb_pkg::ST_SEND_RD: begin
        state_d = mfb_pkg::ST_SEND_DATA;
      end
      mfb_pkg::ST_SEND_DATA: begin
        if (sts_i.out_free) begin
          state_d = sts_i.byte_last ? mfb_pkg::ST_IDLE : mfb_pkg::ST_SEND_RD;
        end
      end
      default: state_d = mfb_pkg::ST_CLEAR;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.out_sel = mfb_pkg::SEL_DATA;
    case (state_q)
      mfb_pkg::ST_CLEAR: begin
        cmd_o.wr_en      = 1'b1;
        cmd_o.wr_zero    = 1'b1;
        cmd_o.sweep_step = 1'b1;
      end
      mfb_pkg::ST_IDLE: begin
        // The store byte under the pixel is read while the beat is taken.
        in_ready_o   = 1'b1;
        cmd_o.cap_en = in_valid_i;
        cmd_o.rd_en  = in_valid_i;
      end
      mfb_pkg::ST_PIX_WR: begin
        cmd_o.wr_en = 1'b1;
      end
      mfb_pkg::ST_SEND_CMD0: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_sel  = mfb_pkg::SEL_CMD0;
      end
      mfb_pkg::ST_SEND_CMD1: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_sel  = mfb_pkg::SEL_CMD1;
      end
      mfb_pkg::ST_SEND_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_send = 1'b1;
      end
      mfb_pkg::ST_SEND_DATA: begin
        cmd_o.out_load   = sts_i.out_free;
        cmd_o.out_sel    = mfb_pkg::SEL_DATA;
        cmd_o.byte_step  = sts_i.out_free;
        cmd_o.cursor_adv = sts_i.out_free && sts_i.byte_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/mfb_dpath.sv */
// ============================================================================
// mfb_dpath: datapath of the framebuffer refresh block
// Holds the frame store, the sweep, byte and row counters, the pixel
// read-modify-write logic and the registered transfer output.
// ============================================================================
module mfb_dpath #(
  parameter int ROWS          = mfb_pkg::ROWS_DEF,
  parameter int BYTES_PER_ROW = mfb_pkg::BYTES_PER_ROW_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mfb_pkg::ctrl_cmd_t           cmd_i,
  output mfb_pkg::ctrl_sts_t           sts_o,
  input  logic [mfb_pkg::OP_W-1:0]     opcode_i,
  input  logic [mfb_pkg::X_W-1:0]      x_pos_i,
  input  logic [mfb_pkg::Y_W-1:0]      y_pos_i,
  input  logic [mfb_pkg::VAL_W-1:0]    pixel_value_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic                         is_data_o,
  output logic [mfb_pkg::BYTE_W-1:0]   payload_byte_o,
  output logic [mfb_pkg::WORD_W-1:0]   serial_word_o,
  output logic                         row_last_o,
  output logic                         frame_last_o
);

  localparam int COL_W   = mfb_pkg::COL_W;
  localparam int ROW_W   = mfb_pkg::ROW_W;
  localparam int BYTE_W  = mfb_pkg::BYTE_W;
  localparam int HALF_W  = mfb_pkg::HALF_W;
  localparam int DEPTH   = ROWS * mfb_pkg::STRIDE;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int RIDX_W  = ADDR_W - COL_W;
  localparam int BCNT_W  = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
  localparam int YCMP_W  = mfb_pkg::Y_W + 1;
  localparam int CCMP_W  = COL_W + 1;
  localparam int RCMP_W  = ROW_W + 1;

  logic [BYTE_W-1:0]  mem [DEPTH];
  logic [BYTE_W-1:0]  rd_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [BYTE_W-1:0]  mask_q;
  logic               set_q;
  logic [ADDR_W-1:0]  sweep_q;
  logic [BCNT_W-1:0]  byte_q;
  logic [ROW_W-1:0]   cursor_q;
  logic               out_valid_q;
  logic               is_data_q;
  logic [BYTE_W-1:0]  byte_out_q;
  logic               row_last_q;
  logic               frame_last_q;

  logic [COL_W-1:0]   in_col;
  logic [ADDR_W-1:0]  in_addr;
  logic [ADDR_W-1:0]  send_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic [BYTE_W-1:0]  wr_data;
  logic               sweep_last;
  logic               byte_last;
  logic               cursor_last;
  logic               out_free;
  logic [BYTE_W-1:0]  byte_out_d;
  logic               row_last_d;

  // Addresses: request pixel, current row byte, sweep position.
  assign in_col    = x_pos_i[mfb_pkg::X_W-1 -: COL_W];
  assign in_addr   = {y_pos_i[RIDX_W-1:0], in_col};
  assign send_addr = {cursor_q[RIDX_W-1:0], COL_W'(byte_q)};
  assign rd_addr   = cmd_i.rd_send ? send_addr : in_addr;
  assign wr_addr   = cmd_i.wr_zero ? sweep_q : addr_q;

  // Pixel merge into the byte read on the previous cycle.
  assign wr_data = cmd_i.wr_zero ? '0 :
                   (set_q ? (rd_q | mask_q) : (rd_q & ~mask_q));

  // Frame store with one write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.rd_en) rd_q <= mem[rd_addr];
  end

  // Capture of the draw request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      addr_q <= in_addr;
      mask_q <= mfb_pkg::PIX_MSB >> x_pos_i[mfb_pkg::X_W-COL_W-1:0];
      set_q  <= pixel_value_i[0];
    end
  end

  assign sweep_last  = (sweep_q == ADDR_W'(DEPTH - 1));
  assign byte_last   = (byte_q == BCNT_W'(BYTES_PER_ROW - 1));
  assign cursor_last = (cursor_q == ROW_W'(ROWS - 1));

  // Counters: clearing sweep, byte within the row, row cursor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q  <= '0;
      byte_q   <= '0;
      cursor_q <= '0;
    end else begin
      if (cmd_i.sweep_step) sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
      if (cmd_i.byte_step) byte_q <= byte_last ? '0 : byte_q + 1'b1;
      if (cmd_i.cursor_adv) cursor_q <= cursor_last ? '0 : cursor_q + 1'b1;
    end
  end

  // Transfer byte selection; the row address splits the screen in halves.
  always_comb begin
    case (cmd_i.out_sel)
      mfb_pkg::SEL_CMD0: byte_out_d = mfb_pkg::ROW_CMD | BYTE_W'(cursor_q[HALF_W-1:0]);
      mfb_pkg::SEL_CMD1: byte_out_d = cursor_q[HALF_W] ? mfb_pkg::BANK_HI : mfb_pkg::BANK_LO;
      mfb_pkg::SEL_DATA: byte_out_d = rd_q;
      default:           byte_out_d = rd_q;
    endcase
  end
  assign row_last_d = (cmd_i.out_sel == mfb_pkg::SEL_DATA) && byte_last;

  // Output register; a beat may be loaded in the cycle the old one leaves.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      is_data_q    <= (cmd_i.out_sel == mfb_pkg::SEL_DATA);
      byte_out_q   <= byte_out_d;
      row_last_q   <= row_last_d;
      frame_last_q <= row_last_d && cursor_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_data_o      = is_data_q;
  assign payload_byte_o = byte_out_q;
  assign serial_word_o  = {is_data_q ? mfb_pkg::SYNC_DATA : mfb_pkg::SYNC_CMD,
                           byte_out_q & mfb_pkg::NIB_MASK,
                           byte_out_q[BYTE_W/2-1:0], (BYTE_W/2)'(0)};
  assign row_last_o     = row_last_q;
  assign frame_last_o   = frame_last_q;

  // Status to the controller.
  assign sts_o.in_op      = mfb_pkg::opcode_e'(opcode_i);
  assign sts_o.draw_ok    = (pixel_value_i <= mfb_pkg::VAL_W'(1)) &&
                            ({1'b0, y_pos_i} < YCMP_W'(ROWS)) &&
                            ({1'b0, in_col} < CCMP_W'(BYTES_PER_ROW));
  assign sts_o.sweep_last = sweep_last;
  assign sts_o.byte_last  = byte_last;
  assign sts_o.out_free   = out_free;

  // A held beat is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("transfer register loaded while a beat is pending");

  // The frame end marker only rides on the closing data beat of a row.
  a_frame_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && frame_last_q) |-> (row_last_q && is_data_q))
    else $error("frame end without row end data beat");

  // The row cursor stays within the frame.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cursor_q} < RCMP_W'(ROWS)))
    else $error("row cursor beyond last row");

  // A pixel write always follows the read of its byte.
  a_rmw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_en && !cmd_i.wr_zero) |-> ($past(cmd_i.cap_en) && $past(cmd_i.rd_en)))
    else $error("pixel write without preceding read");

endmodule

/* hw/rtl/mono_framebuffer_serial_refresh.sv */
// ============================================================================
// mono_framebuffer_serial_refresh: one-bit framebuffer with serial row refresh
// Request channel in, serial display transfer channel out.
// ============================================================================
// The request channel takes one beat at a time: draw a pixel, clear the
// store, send the next row, or a no-op. The transfer channel gives one
// display transfer per beat (command flag, byte, three-byte serial word,
// row and frame end markers). Draw and clear give no transfers.
// A draw reads the store byte while the beat is taken, then writes it back.
// A no-op or a bad draw only takes the beat. A clear zeroes one store byte
// per cycle over all ROWS*16 bytes of the store. A send gives two address
// commands, then each row byte needs one store read and one output load.
// The first transfer of a send is loaded in the first send state once the
// output register is free. The registered store read and the one-deep
// output register shape these steps.
// A transfer beat waits in the output register while the receiver stalls;
// the sequencer holds and no beat is lost. A request may be taken while the
// last transfer of a row still waits to be taken.
// After reset the store is zeroed by a clearing pass over all ROWS*16
// store bytes (1024 by default) before the first request is accepted; the row
// cursor starts at row 0 and wraps after the last row.
// ============================================================================
module mono_framebuffer_serial_refresh #(
  parameter int ROWS          = mfb_pkg::ROWS_DEF,
  parameter int BYTES_PER_ROW = mfb_pkg::BYTES_PER_ROW_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mfb_in_if.sink        in_i,
  mfb_out_if.source     out_o
);

  mfb_pkg::ctrl_cmd_t cmd;
  mfb_pkg::ctrl_sts_t sts;
  logic               in_ready;

  assign in_i.ready = in_ready;

  mfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mfb_dpath #(
    .ROWS          (ROWS),
    .BYTES_PER_ROW (BYTES_PER_ROW)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (in_i.opcode),
    .x_pos_i        (in_i.x_pos),
    .y_pos_i        (in_i.y_pos),
    .pixel_value_i  (in_i.pixel_value),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .is_data_o      (out_o.is_data),
    .payload_byte_o (out_o.payload_byte),
    .serial_word_o  (out_o.serial_word),
    .row_last_o     (out_o.row_last),
    .frame_last_o   (out_o.frame_last)
  );

endmodule
